// File: design/q_learning_table_update_top_assert.svh
// Assertion macros shared by the Q-learning table update block.
// Each macro expects a clock named clk and a synchronous reset named rst.
`ifndef Q_LEARNING_TABLE_UPDATE_TOP_ASSERT_SVH
`define Q_LEARNING_TABLE_UPDATE_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QLT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define QLT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/qlt_pkg.sv
// ----------------------------------------------------------------------------
// qlt_pkg
// Shared sizes, codes and reset values of the Q-learning table update block.
// ----------------------------------------------------------------------------
package qlt_pkg;

  localparam int NUM_STATES  = 256;
  localparam int NUM_ACTIONS = 8;
  localparam int Q_WIDTH     = 32;

  localparam int STATE_W = $clog2(NUM_STATES);
  localparam int ACT_W   = $clog2(NUM_ACTIONS);
  localparam int CNT_W   = $clog2(NUM_ACTIONS + 1);
  localparam int TBL_DEPTH = NUM_STATES * NUM_ACTIONS;
  localparam int ADDR_W  = STATE_W + ACT_W;

  localparam int FACTOR_W = 17;
  localparam int DRAW_W   = 16;

  typedef enum logic [1:0] {
    REQ_START  = 2'd0,
    REQ_CHOOSE = 2'd1,
    REQ_APPLY  = 2'd2,
    REQ_QUERY  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NO_ACTION = 2'd1,
    STATUS_SATURATED = 2'd2
  } status_t;

  localparam logic [1:0] REG_LEARNING_RATE   = 2'd0;
  localparam logic [1:0] REG_DISCOUNT_FACTOR = 2'd1;
  localparam logic [1:0] REG_EXPLORE_FACTOR  = 2'd2;

  localparam logic [FACTOR_W-1:0] LR_RESET      = 17'd32768;
  localparam logic [FACTOR_W-1:0] DISCOUNT_RESET = 17'd52429;
  localparam logic [FACTOR_W-1:0] EXPLORE_RESET = 17'd52429;

endpackage

// File: design/qlt_ram.sv
// ----------------------------------------------------------------------------
// qlt_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module qlt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: design/q_learning_table_update_top.sv
// ----------------------------------------------------------------------------
// q_learning_table_update_top
// Tabular Q-learning engine with epsilon-greedy action choice.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    req_type .. reward
//   out      output     out_valid/out_ready  chosen_action .. status
//   cfg      input      cfg_write            cfg_index, cfg_data
//
// Each request's run time is set by the one read port of the Q table (eight
// reads for a state scan) and, for explored choices, a one-bit-per-cycle
// remainder of the pick draw.
// Start and reset clear all 2048 entries in one pass, one entry per cycle,
// during which no transaction is accepted on the input channel.
// A stalled output holds the finished result; the next input transaction is
// accepted meanwhile and its result waits until the output register is free.
// ----------------------------------------------------------------------------
`include "q_learning_table_update_top_assert.svh"

module q_learning_table_update_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          req_type,
  input  logic [7:0]                          state_index,
  input  logic [2:0]                          action_index,
  input  logic [7:0]                          action_mask,
  input  logic [15:0]                         explore_draw,
  input  logic [15:0]                         pick_draw,
  input  logic signed [31:0]                  reward,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [2:0]                          chosen_action,
  output logic                                explored,
  output logic signed [31:0]                  q_out,
  output logic [7:0]                          state_out,
  output logic [1:0]                          status,
  input  logic                                cfg_write,
  input  logic [1:0]                          cfg_index,
  input  logic [16:0]                         cfg_data
);

  localparam int QW    = qlt_pkg::Q_WIDTH;
  localparam int P1_W  = QW + qlt_pkg::FACTOR_W + 1;
  localparam int T_W   = P1_W - 16 + 1;
  localparam int D_W   = T_W + 1;
  localparam int P2_W  = D_W + qlt_pkg::FACTOR_W + 1;
  localparam int N_W   = P2_W - 16 + 1;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_SCAN, ST_RDQ, ST_WAITQ, ST_MUL1, ST_ADD1,
    ST_MUL2, ST_FIN, ST_MOD, ST_PICK, ST_QRD, ST_QWAIT, ST_DONE
  } state_t;

  state_t state;

  logic [qlt_pkg::FACTOR_W-1:0] learning_rate, discount_factor, explore_factor;
  logic [qlt_pkg::STATE_W-1:0]  current_state;

  // Captured request.
  qlt_pkg::req_t                req;
  logic [qlt_pkg::STATE_W-1:0]  sidx;
  logic [qlt_pkg::ACT_W-1:0]    aidx;
  logic [7:0]                   mask;
  logic [qlt_pkg::DRAW_W-1:0]   pdraw;
  logic signed [31:0]           rew;
  logic [qlt_pkg::CNT_W-1:0]    cnt;

  logic [qlt_pkg::ADDR_W-1:0]   clr_addr;
  logic                         clr_report;

  logic [qlt_pkg::CNT_W-1:0]    scan_cnt;
  logic                         rd_vld;
  logic [qlt_pkg::ACT_W-1:0]    rd_act;
  logic                         have;
  logic signed [QW-1:0]         best;
  logic [qlt_pkg::ACT_W-1:0]    best_act;

  logic signed [QW-1:0]         q_val;
  logic signed [P1_W-1:0]       prod1;
  logic signed [D_W-1:0]        diff;
  logic signed [P2_W-1:0]       prod2;

  logic [3:0]                   bit_cnt;
  logic [qlt_pkg::CNT_W-1:0]    rem;

  // Result waiting for the output register.
  logic [qlt_pkg::ACT_W-1:0]    res_act;
  logic                         res_expl;
  logic signed [QW-1:0]         res_q;
  qlt_pkg::status_t             res_status;

  logic                         ram_we;
  logic [qlt_pkg::ADDR_W-1:0]   ram_addr;
  logic [QW-1:0]                ram_wdata;
  logic [QW-1:0]                ram_rdata;

  qlt_ram #(.WIDTH(QW), .DEPTH(qlt_pkg::TBL_DEPTH)) u_qtable (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Population count of the incoming mask.
  logic [qlt_pkg::CNT_W-1:0] in_cnt;
  always_comb begin
    in_cnt = '0;
    for (int i = 0; i < qlt_pkg::NUM_ACTIONS; i++) begin
      in_cnt = in_cnt + qlt_pkg::CNT_W'(action_mask[i]);
    end
  end

  // Action whose rank among the valid ones equals the remainder.
  logic [qlt_pkg::ACT_W-1:0] pick_act;
  logic [qlt_pkg::CNT_W-1:0] seen;
  logic                      found;
  always_comb begin
    pick_act = '0;
    seen     = '0;
    found    = 1'b0;
    for (int i = 0; i < qlt_pkg::NUM_ACTIONS; i++) begin
      if (mask[i] && !found) begin
        if (seen == rem) begin
          pick_act = qlt_pkg::ACT_W'(i);
          found    = 1'b1;
        end else begin
          seen = seen + 1'b1;
        end
      end
    end
  end

  logic [qlt_pkg::STATE_W-1:0] scan_state;
  assign scan_state = (req == qlt_pkg::REQ_APPLY) ? sidx : current_state;

  logic signed [QW-1:0] maxq;
  assign maxq = have ? best : '0;

  // Limits of the Q range, widened to the width of the final sum.
  localparam logic signed [N_W-1:0] N_Q_MAX = {{(N_W-QW+1){1'b0}}, {(QW-1){1'b1}}};
  localparam logic signed [N_W-1:0] N_Q_MIN = {{(N_W-QW+1){1'b1}}, {(QW-1){1'b0}}};

  // Final sum and clamp of the update.
  logic signed [N_W-1:0] n_full;
  logic signed [QW-1:0]  n_clamped;
  logic                  n_sat;
  always_comb begin
    n_full = N_W'(q_val) + N_W'(prod2 >>> 16);
    n_sat  = 1'b0;
    if (n_full > N_Q_MAX) begin
      n_clamped = {1'b0, {(QW-1){1'b1}}};
      n_sat     = 1'b1;
    end else if (n_full < N_Q_MIN) begin
      n_clamped = {1'b1, {(QW-1){1'b0}}};
      n_sat     = 1'b1;
    end else begin
      n_clamped = n_full[QW-1:0];
    end
  end

  logic [qlt_pkg::CNT_W:0] rem_shift;
  assign rem_shift = {rem, pdraw[bit_cnt]};

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = '0;
    ram_addr  = {sidx, aidx};
    unique case (state)
      ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_addr;
      end
      ST_SCAN:  ram_addr = {scan_state, scan_cnt[qlt_pkg::ACT_W-1:0]};
      ST_RDQ:   ram_addr = {current_state, aidx};
      ST_FIN: begin
        ram_we    = 1'b1;
        ram_addr  = {current_state, aidx};
        ram_wdata = n_clamped;
      end
      default:  ram_addr = {sidx, aidx};
    endcase
  end

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_CLEAR;
      clr_addr        <= '0;
      clr_report      <= 1'b0;
      current_state   <= '0;
      learning_rate   <= qlt_pkg::LR_RESET;
      discount_factor <= qlt_pkg::DISCOUNT_RESET;
      explore_factor  <= qlt_pkg::EXPLORE_RESET;
      out_valid       <= 1'b0;
      rd_vld          <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          qlt_pkg::REG_LEARNING_RATE:   learning_rate   <= cfg_data;
          qlt_pkg::REG_DISCOUNT_FACTOR: discount_factor <= cfg_data;
          qlt_pkg::REG_EXPLORE_FACTOR:  explore_factor  <= cfg_data;
          default: ;
        endcase
      end
      // A waiting result reloads the register in the same cycle instead.
      if (out_valid && out_ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (&clr_addr) begin
            state <= clr_report ? ST_DONE : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            req        <= qlt_pkg::req_t'(req_type);
            sidx       <= state_index;
            aidx       <= action_index;
            mask       <= action_mask;
            pdraw      <= pick_draw;
            rew        <= reward;
            cnt        <= in_cnt;
            res_act    <= '0;
            res_q      <= '0;
            scan_cnt   <= '0;
            rd_vld     <= 1'b0;
            have       <= 1'b0;
            best       <= '0;
            best_act   <= '0;
            bit_cnt    <= 4'(qlt_pkg::DRAW_W - 1);
            rem        <= '0;
            unique case (qlt_pkg::req_t'(req_type))
              qlt_pkg::REQ_START: begin
                current_state <= state_index;
                clr_addr      <= '0;
                clr_report    <= 1'b1;
                res_expl      <= 1'b0;
                res_status    <= qlt_pkg::STATUS_OK;
                state         <= ST_CLEAR;
              end
              qlt_pkg::REQ_CHOOSE: begin
                if (in_cnt == '0) begin
                  res_expl   <= 1'b0;
                  res_status <= qlt_pkg::STATUS_NO_ACTION;
                  state      <= ST_DONE;
                end else if ({1'b0, explore_draw} < explore_factor) begin
                  res_expl   <= 1'b1;
                  res_status <= qlt_pkg::STATUS_OK;
                  state      <= ST_MOD;
                end else begin
                  res_expl   <= 1'b0;
                  res_status <= qlt_pkg::STATUS_OK;
                  state      <= ST_SCAN;
                end
              end
              qlt_pkg::REQ_APPLY: begin
                res_expl   <= 1'b0;
                res_status <= qlt_pkg::STATUS_OK;
                state      <= ST_SCAN;
              end
              qlt_pkg::REQ_QUERY: begin
                res_expl   <= 1'b0;
                res_status <= qlt_pkg::STATUS_OK;
                state      <= ST_QRD;
              end
            endcase
          end
        end
        ST_SCAN: begin
          // Reads are issued one per cycle; each read returns in the next cycle.
          scan_cnt <= scan_cnt + 1'b1;
          rd_vld   <= (scan_cnt < qlt_pkg::CNT_W'(qlt_pkg::NUM_ACTIONS));
          rd_act   <= scan_cnt[qlt_pkg::ACT_W-1:0];
          if (rd_vld && mask[rd_act]) begin
            if (!have || $signed(ram_rdata) > best) begin
              best     <= ram_rdata;
              best_act <= rd_act;
              have     <= 1'b1;
            end
          end
          if (scan_cnt == qlt_pkg::CNT_W'(qlt_pkg::NUM_ACTIONS)) begin
            if (req == qlt_pkg::REQ_APPLY) begin
              state <= ST_RDQ;
            end else begin
              state <= ST_PICK;
            end
          end
        end
        ST_RDQ:   state <= ST_WAITQ;
        ST_WAITQ: begin
          q_val <= ram_rdata;
          state <= ST_MUL1;
        end
        ST_MUL1: begin
          prod1 <= maxq * $signed({1'b0, discount_factor});
          state <= ST_ADD1;
        end
        ST_ADD1: begin
          diff  <= D_W'(rew) + D_W'(prod1 >>> 16) - D_W'(q_val);
          state <= ST_MUL2;
        end
        ST_MUL2: begin
          prod2 <= diff * $signed({1'b0, learning_rate});
          state <= ST_FIN;
        end
        ST_FIN: begin
          res_q         <= n_clamped;
          res_status    <= n_sat ? qlt_pkg::STATUS_SATURATED : qlt_pkg::STATUS_OK;
          current_state <= sidx;
          state         <= ST_DONE;
        end
        ST_MOD: begin
          // Restoring remainder, one draw bit per cycle, most significant first.
          if (rem_shift >= {1'b0, cnt}) begin
            rem <= qlt_pkg::CNT_W'(rem_shift - {1'b0, cnt});
          end else begin
            rem <= rem_shift[qlt_pkg::CNT_W-1:0];
          end
          bit_cnt <= bit_cnt - 1'b1;
          if (bit_cnt == '0) begin
            state <= ST_PICK;
          end
        end
        ST_PICK: begin
          res_act <= res_expl ? pick_act : best_act;
          state   <= ST_DONE;
        end
        ST_QRD:   state <= ST_QWAIT;
        ST_QWAIT: begin
          res_q <= ram_rdata;
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            chosen_action <= res_act;
            explored      <= res_expl;
            q_out         <= res_q;
            state_out     <= current_state;
            status        <= res_status;
            clr_report    <= 1'b0;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `QLT_ASSERT_NOW(a_write_only_clear_or_fin, ram_we, (state == ST_CLEAR) || (state == ST_FIN),
    "Q table written outside clearing or update")
  `QLT_ASSERT_NOW(a_no_action_clean, out_valid && (status == qlt_pkg::STATUS_NO_ACTION),
    (chosen_action == '0) && !explored, "empty mask result carries an action")
  `QLT_ASSERT_NOW(a_explored_ok, out_valid && explored, status == qlt_pkg::STATUS_OK,
    "explored choice reports a bad status")
  `QLT_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, state != ST_IDLE,
    "accepted transaction did not start work")

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// Q-learning table update testbench
// Drives request transactions into the Q-learning engine with random gaps and
// output stalls, predicts each result with a local copy of the Q table and the
// configuration, and compares every result field by field.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [1:0] req_type;
  logic [7:0] state_index, action_mask;
  logic [2:0] action_index;
  logic [15:0] explore_draw, pick_draw;
  logic signed [31:0] reward;
  logic [2:0] chosen_action;
  logic explored;
  logic signed [31:0] q_out;
  logic [7:0] state_out;
  logic [1:0] status;
  logic cfg_write;
  logic [1:0] cfg_index;
  logic [16:0] cfg_data;

  q_learning_table_update_top dut (.*);

  typedef struct packed {
    logic [2:0] action;
    logic explored;
    logic [31:0] q;
    logic [7:0] state;
    logic [1:0] status;
  } outcome_t;

  typedef struct {
    qlt_pkg::req_t req;
    logic [7:0] sidx;
    logic [2:0] aidx;
    logic [7:0] mask;
    logic [15:0] edraw;
    logic [15:0] pdraw;
    logic [31:0] rwd;
    bit typed;
    outcome_t want;
  } request_t;

  localparam longint I64_MAX = 64'sh7fffffffffffffff;
  localparam longint I64_MIN = 64'sh8000000000000000;
  localparam int LIMIT = 3_000_000;

  longint q_mem [qlt_pkg::TBL_DEPTH];
  logic [7:0] cur_state;
  logic [16:0] alpha, gamma_f, epsilon;
  outcome_t pending_q[$];
  int mismatches, results_seen, cycles;
  int n_explored, n_saturated, n_empty;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench failed");
      $finish;
    end
  end

  function automatic longint add_sat(longint a, longint b, ref bit sat);
    if (b > 0 && a > I64_MAX - b) begin sat = 1; return I64_MAX; end
    if (b < 0 && a < I64_MIN - b) begin sat = 1; return I64_MIN; end
    return a + b;
  endfunction

  function automatic longint sub_sat(longint a, longint b, ref bit sat);
    if (b < 0 && a > I64_MAX + b) begin sat = 1; return I64_MAX; end
    if (b > 0 && a < I64_MIN + b) begin sat = 1; return I64_MIN; end
    return a - b;
  endfunction

  // Floor of a*f/2^16, split so that the partial products cannot overflow.
  function automatic longint scale_q16(longint a, logic [16:0] f, ref bit sat);
    longint lo, hi, fb;
    lo = a & 64'hffff;
    hi = (a - lo) / 65536;
    fb = longint'(f);
    if (fb == 0) return 0;
    if (hi > I64_MAX / fb) begin sat = 1; return I64_MAX; end
    if (hi < I64_MIN / fb) begin sat = 1; return I64_MIN; end
    return add_sat(hi * fb, (lo * fb) / 65536, sat);
  endfunction

  function automatic outcome_t predict_q_step(request_t r);
    outcome_t o;
    int cnt, k, seen;
    bit have, sat;
    longint best, v, q, t, d, n;
    int pos;
    o = '0;
    case (r.req)
      qlt_pkg::REQ_START: begin
        foreach (q_mem[i]) q_mem[i] = 0;
        cur_state = r.sidx;
      end
      qlt_pkg::REQ_CHOOSE: begin
        cnt = $countones(r.mask);
        if (cnt == 0) o.status = qlt_pkg::STATUS_NO_ACTION;
        else if (r.edraw < epsilon) begin
          o.explored = 1;
          k = r.pdraw % cnt;
          seen = 0;
          for (int i = 0; i < qlt_pkg::NUM_ACTIONS; i++)
            if (r.mask[i]) begin
              if (seen == k) begin o.action = 3'(i); break; end
              seen++;
            end
        end else begin
          have = 0;
          best = 0;
          for (int i = 0; i < qlt_pkg::NUM_ACTIONS; i++)
            if (r.mask[i]) begin
              v = q_mem[cur_state * qlt_pkg::NUM_ACTIONS + i];
              if (!have || v > best) begin best = v; o.action = 3'(i); have = 1; end
            end
        end
      end
      qlt_pkg::REQ_APPLY: begin
        sat = 0;
        have = 0;
        best = 0;
        for (int i = 0; i < qlt_pkg::NUM_ACTIONS; i++)
          if (r.mask[i]) begin
            v = q_mem[r.sidx * qlt_pkg::NUM_ACTIONS + i];
            if (!have || v > best) begin best = v; have = 1; end
          end
        pos = cur_state * qlt_pkg::NUM_ACTIONS + r.aidx;
        q = q_mem[pos];
        t = add_sat(longint'(signed'(r.rwd)), scale_q16(best, gamma_f, sat), sat);
        d = sub_sat(t, q, sat);
        n = add_sat(q, scale_q16(d, alpha, sat), sat);
        if (n > 64'sh7fffffff) begin n = 64'sh7fffffff; sat = 1; end
        if (n < -64'sh80000000) begin n = -64'sh80000000; sat = 1; end
        q_mem[pos] = n;
        o.q = n[31:0];
        if (sat) o.status = qlt_pkg::STATUS_SATURATED;
        cur_state = r.sidx;
      end
      default: o.q = q_mem[r.sidx * qlt_pkg::NUM_ACTIONS + r.aidx][31:0];
    endcase
    o.state = cur_state;
    return o;
  endfunction

  // Output side: random stalls, every transaction checked against the oldest
  // expectation.
  initial begin
    int wait_n;
    outcome_t got, want;
    out_ready = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
      if (wait_n != 0) begin
        out_ready <= 0;
        repeat (wait_n) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got = '{chosen_action, explored, q_out, state_out, status};
      results_seen++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: act %0d/%0d expl %0d/%0d q %h/%h st %0d/%0d stat %0d/%0d",
                     want.action, got.action, want.explored, got.explored, want.q,
                     got.q, want.state, got.state, want.status, got.status);
        end
      end
    end
  end

  // Valid stays high after an acceptance only when the next transaction
  // follows at once, in which case the payload changes at that same edge.
  task automatic send_request(request_t r);
    int wait_n;
    outcome_t o;
    wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
    if (wait_n != 0) begin
      in_valid <= 0;
      repeat (wait_n) @(posedge clk);
    end
    in_valid <= 1;
    req_type <= r.req;
    state_index <= r.sidx;
    action_index <= r.aidx;
    action_mask <= r.mask;
    explore_draw <= r.edraw;
    pick_draw <= r.pdraw;
    reward <= r.rwd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    o = predict_q_step(r);
    if (o.explored) n_explored++;
    if (o.status == qlt_pkg::STATUS_SATURATED) n_saturated++;
    if (o.status == qlt_pkg::STATUS_NO_ACTION) n_empty++;
    if (r.typed && o !== r.want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("directed row: expected %h, predicted %h", r.want, o);
    end
    pending_q.push_back(o);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [16:0] val);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      qlt_pkg::REG_LEARNING_RATE: alpha = val;
      qlt_pkg::REG_DISCOUNT_FACTOR: gamma_f = val;
      default: epsilon = val;
    endcase
  endtask

  task automatic drain_results();
    in_valid <= 0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic request_t mk(qlt_pkg::req_t t, int s, int a, int m, int e, int p,
                                  logic [31:0] rw);
    request_t r;
    r = '{t, 8'(s), 3'(a), 8'(m), 16'(e), 16'(p), rw, 1'b0, '0};
    return r;
  endfunction

  function automatic request_t mk_typed(request_t r, outcome_t w);
    r.typed = 1;
    r.want = w;
    return r;
  endfunction

  function automatic request_t random_request(int focus_state);
    request_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r = mk(qlt_pkg::REQ_QUERY, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    if (pick < 2) r.req = qlt_pkg::REQ_START;
    else if (pick < 40) r.req = qlt_pkg::REQ_CHOOSE;
    else if (pick < 85) r.req = qlt_pkg::REQ_APPLY;
    // Keep most transitions among a few states so the table fills up.
    if (pick < 90 && $urandom_range(0, 3) != 0)
      r.sidx = 8'($urandom_range(0, 3) + focus_state);
    if ($urandom_range(0, 9) == 0) r.mask = 0;
    case ($urandom_range(0, 5))
      0: r.rwd = 32'($urandom_range(0, 65536 * 4));
      1: r.rwd = 32'(-$urandom_range(0, 65536 * 4));
      2: r.rwd = {1'b0, {31{1'b1}}};
      3: r.rwd = {1'b1, 31'b0};
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    request_t rows[$];
    logic [16:0] settings[5][3];
    int focus;
    rst = 1;
    in_valid = 0;
    req_type = qlt_pkg::REQ_START;
    state_index = 0;
    action_index = 0;
    action_mask = 0;
    explore_draw = 0;
    pick_draw = 0;
    reward = 0;
    cfg_write = 0;
    cfg_index = qlt_pkg::REG_LEARNING_RATE;
    cfg_data = 0;
    mismatches = 0;
    cycles = 0;
    foreach (q_mem[i]) q_mem[i] = 0;
    cur_state = 0;
    alpha = qlt_pkg::LR_RESET;
    gamma_f = qlt_pkg::DISCOUNT_RESET;
    epsilon = qlt_pkg::EXPLORE_RESET;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed table: reset state, empty masks, explore and greedy paths,
    // reward extremes and saturation.
    rows.push_back(mk_typed(mk(qlt_pkg::REQ_QUERY, 255, 7, 0, 0, 0, 0), '0));
    rows.push_back(mk_typed(mk(qlt_pkg::REQ_CHOOSE, 0, 0, 0, 0, 0, 0),
                            '{0, 0, 0, 0, qlt_pkg::STATUS_NO_ACTION}));
    rows.push_back(mk_typed(mk(qlt_pkg::REQ_CHOOSE, 0, 0, 8'hff, 0, 65535, 0),
                            '{7, 1, 0, 0, qlt_pkg::STATUS_OK}));
    rows.push_back(mk_typed(mk(qlt_pkg::REQ_CHOOSE, 0, 0, 8'h90, 65535, 0, 0),
                            '{4, 0, 0, 0, qlt_pkg::STATUS_OK}));
    rows.push_back(mk_typed(mk(qlt_pkg::REQ_START, 200, 0, 0, 0, 0, 0),
                            '{0, 0, 0, 200, qlt_pkg::STATUS_OK}));
    rows.push_back(mk(qlt_pkg::REQ_APPLY, 201, 3, 0, 0, 0, 32'h7fffffff));
    rows.push_back(mk(qlt_pkg::REQ_APPLY, 200, 5, 8'h81, 0, 0, 32'h80000000));
    rows.push_back(mk(qlt_pkg::REQ_APPLY, 200, 5, 8'hff, 0, 0, 32'h80000000));
    rows.push_back(mk(qlt_pkg::REQ_APPLY, 201, 2, 8'h24, 0, 0, 32'h00010000));
    rows.push_back(mk(qlt_pkg::REQ_CHOOSE, 0, 0, 8'hff, 52429, 0, 0));
    rows.push_back(mk(qlt_pkg::REQ_CHOOSE, 0, 0, 8'h6c, 52428, 12345, 0));
    rows.push_back(mk(qlt_pkg::REQ_QUERY, 200, 5, 0, 0, 0, 0));
    rows.push_back(mk(qlt_pkg::REQ_QUERY, 201, 3, 0, 0, 0, 0));
    foreach (rows[i]) send_request(rows[i]);
    drain_results();

    // Register settings including both extremes and gains above one.
    settings = '{'{0, 0, 0}, '{17'h1ffff, 17'h1ffff, 17'h1ffff},
                 '{65536, 65536, 65536}, '{32768, 52429, 52429}, '{4096, 60000, 8000}};
    rows.delete();
    rows.push_back(mk(qlt_pkg::REQ_APPLY, 10, 1, 8'hff, 0, 0, 32'h7fffffff));
    rows.push_back(mk(qlt_pkg::REQ_APPLY, 10, 1, 8'hff, 0, 0, 32'h7fffffff));
    rows.push_back(mk(qlt_pkg::REQ_CHOOSE, 0, 0, 8'h0f, 65535, 3, 0));
    rows.push_back(mk(qlt_pkg::REQ_APPLY, 11, 0, 8'h00, 0, 0, 32'h80000000));
    foreach (settings[s]) begin
      write_reg(qlt_pkg::REG_LEARNING_RATE, settings[s][0]);
      write_reg(qlt_pkg::REG_DISCOUNT_FACTOR, settings[s][1]);
      write_reg(qlt_pkg::REG_EXPLORE_FACTOR, settings[s][2]);
      cfg_write <= 0;
      foreach (rows[i]) send_request(rows[i]);
      focus = $urandom_range(0, 252);
      for (int n = 0; n < 320; n++) send_request(random_request(focus));
      drain_results();
    end

    $display("%0d results checked, %0d explored choices, %0d saturated updates,",
             results_seen, n_explored, n_saturated);
    $display("%0d empty-mask choices, over five register settings", n_empty);
    if (mismatches == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end
endmodule

// File: sim.f
+incdir+design
design/qlt_pkg.sv
design/qlt_ram.sv
design/q_learning_table_update_top.sv
verif/testbench.sv
